// ----- sv/ppu_pkg.sv -----
// ----------------------------------------------------------------------------
// ppu_pkg
// Types and codes shared by the particle pool update block.
// ----------------------------------------------------------------------------
package ppu_pkg;

   localparam int IDX_W  = 7;   // slot counter, holds the pool size itself
   localparam int CSR_IW = 3;
   localparam int REG_W  = 12;
   localparam int POS_W  = 32;
   localparam int VEL_W  = 20;
   localparam int LIFE_W = 8;

   localparam logic CMD_SPAWN = 1'b0;
   localparam logic CMD_TICK  = 1'b1;

   localparam logic [1:0] STATUS_REPORT = 2'd0;
   localparam logic [1:0] STATUS_SPAWN  = 2'd1;
   localparam logic [1:0] STATUS_FULL   = 2'd2;
   localparam logic [1:0] STATUS_NONE   = 2'd3;

   localparam logic [1:0] CLASS_STAR  = 2'd0;
   localparam logic [1:0] CLASS_BREAK = 2'd1;

   localparam logic [CSR_IW-1:0] CSR_STAR_FRICTION  = 3'd0;
   localparam logic [CSR_IW-1:0] CSR_STAR_GRAVITY   = 3'd1;
   localparam logic [CSR_IW-1:0] CSR_BREAK_FRICTION = 3'd2;
   localparam logic [CSR_IW-1:0] CSR_BREAK_GRAVITY  = 3'd3;
   localparam logic [CSR_IW-1:0] CSR_FOG_FRICTION   = 3'd4;
   localparam logic [CSR_IW-1:0] CSR_FOG_GRAVITY    = 3'd5;

   typedef struct packed {
      logic              cmd;
      logic [1:0]        particle_class;
      logic [POS_W-1:0]  start_x;
      logic [POS_W-1:0]  start_y;
      logic [VEL_W-1:0]  start_vx;
      logic [VEL_W-1:0]  start_vy;
      logic [LIFE_W-1:0] life_ticks;
      logic [3:0]        frame_count;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [5:0]       slot;
      logic [POS_W-1:0] pos_x;
      logic [POS_W-1:0] pos_y;
      logic [3:0]       frame;
      logic             last;
   } rsp_type;

   typedef struct packed {
      logic [POS_W-1:0]  x;
      logic [POS_W-1:0]  y;
      logic [VEL_W-1:0]  vx;
      logic [VEL_W-1:0]  vy;
      logic [LIFE_W-1:0] left;
      logic [LIFE_W-1:0] total;
      logic [1:0]        pclass;
      logic [3:0]        frames;
   } rec_type;

   typedef struct packed {
      logic              start;
      logic [LIFE_W-1:0] dividend;
      logic [LIFE_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [LIFE_W-1:0] quot;
   } div_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SP_SCAN,
      ST_SP_RSP,
      ST_TK_SCAN,
      ST_TK_UPD,
      ST_TK_POS,
      ST_TK_DIV1,
      ST_TK_DIV2,
      ST_TK_EMIT,
      ST_TK_FIN
   } state_type;

endpackage

// ----- sv/particle_pool_update.sv -----
// ----------------------------------------------------------------------------
// particle_pool_update
// Fixed pool of particles with per-tick friction, gravity and integration.
// ----------------------------------------------------------------------------
// A spawn walks the live bits from slot 0 to the first free one, one slot a
// cycle, and then waits for the result register. A tick walks all slots: a
// free slot is skipped, a slot that dies is cleared after the registered read
// of the particle RAM, and a surviving slot goes through that read, the
// staged velocity and position update and up to two passes of the shared
// frame divider (eight steps each). Reports come in slot order; the last one
// carries last, and a tick with no survivor gives one none-live result. The
// block takes no item until every result of the current one has entered the
// output register.
module particle_pool_update
   import ppu_pkg::*;
#(
   parameter int POOL_SIZE = 64,
   parameter int FRAC_BITS = 12
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [REG_W-1:0]  csr_data
);

   localparam int AW    = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
   localparam int REC_W = $bits(rec_type);

   localparam logic [REG_W-1:0] RST_STAR_F  = REG_W'(((20 << FRAC_BITS) + 500) / 1000);
   localparam logic [REG_W-1:0] RST_STAR_G  = REG_W'(((40 << FRAC_BITS) + 500) / 1000);
   localparam logic [REG_W-1:0] RST_BREAK_F = REG_W'(((10 << FRAC_BITS) + 500) / 1000);
   localparam logic [REG_W-1:0] RST_BREAK_G = REG_W'(((60 << FRAC_BITS) + 500) / 1000);
   localparam logic [REG_W-1:0] RST_FOG_F   = REG_W'(((15 << FRAC_BITS) + 500) / 1000);
   localparam logic [REG_W-1:0] RST_FOG_G   = REG_W'(((15 << FRAC_BITS) + 500) / 1000);

   localparam logic signed [VEL_W:0] VMAX = (VEL_W+1)'((1 << (VEL_W - 1)) - 1);
   localparam logic signed [VEL_W:0] VMIN = -(VEL_W+1)'(1 << (VEL_W - 1));
   localparam logic signed [POS_W:0] PMAX = {2'b00, {(POS_W-1){1'b1}}};
   localparam logic signed [POS_W:0] PMIN = {2'b11, {(POS_W-1){1'b0}}};

   state_type state_ff, state_in;

   logic [REG_W-1:0] star_f_ff, star_g_ff, break_f_ff, break_g_ff, fog_f_ff, fog_g_ff;

   logic [POOL_SIZE-1:0] live_ff;
   logic [IDX_W-1:0]     idx_ff;
   logic [AW-1:0]        addr;
   logic                 at_end;
   logic                 cur_live;

   req_type           req_ff;
   logic              full_ff;
   logic [VEL_W-1:0]  vx_ff, vy_ff;
   logic [POS_W-1:0]  x_ff, y_ff;
   logic [LIFE_W-1:0] left_ff, total_ff;
   logic [3:0]        frames_ff;
   logic [3:0]        frame_ff;

   logic    rsp_valid_ff;
   rsp_type rsp_ff;
   logic    pend_valid_ff;
   rsp_type pend_ff;

   rec_type     rd_rec, wr_rec;
   logic        ram_we;
   div_req_type div_req;
   div_rsp_type div_rsp;

   logic [REG_W-1:0]      fric, grav;
   logic [VEL_W-1:0]      vx_new, vy_new;
   logic signed [VEL_W:0] vy_sum;
   logic [POS_W-1:0]      x_new, y_new;
   logic [LIFE_W-1:0]     diff_life;
   logic [3:0]            frames_m1;
   logic [3:0]            frame_q;

   function automatic logic [VEL_W-1:0] friction(input logic [VEL_W-1:0] v,
                                                 input logic [REG_W-1:0] f);
      logic signed [VEL_W:0] ve;
      logic signed [VEL_W:0] fe;
      logic signed [VEL_W:0] r;
      ve = {v[VEL_W-1], v};
      fe = (VEL_W+1)'(f);
      r  = '0;
      if (ve > 0) begin
         r = (ve - fe > 0) ? ve - fe : '0;
      end else if (ve < 0) begin
         r = (ve + fe < 0) ? ve + fe : '0;
      end
      return r[VEL_W-1:0];
   endfunction

   function automatic logic [POS_W-1:0] integrate(input logic [POS_W-1:0] p,
                                                  input logic [VEL_W-1:0] v);
      logic signed [POS_W:0] s;
      s = $signed({p[POS_W-1], p}) + $signed({{(POS_W-VEL_W+1){v[VEL_W-1]}}, v});
      if (s > PMAX) begin
         s = PMAX;
      end else if (s < PMIN) begin
         s = PMIN;
      end
      return s[POS_W-1:0];
   endfunction

   ppu_ram #(
      .WIDTH  (REC_W),
      .DEPTH  (POOL_SIZE),
      .ADDR_W (AW)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (addr),
      .wdata (wr_rec),
      .raddr (addr),
      .rdata (rd_rec)
   );

   ppu_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign addr     = idx_ff[AW-1:0];
   assign at_end   = (idx_ff == IDX_W'(POOL_SIZE));
   assign cur_live = live_ff[addr];

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // class registers, classes two and three both fall onto fog
   always_comb begin
      case (rd_rec.pclass)
         CLASS_STAR: begin
            fric = star_f_ff;
            grav = star_g_ff;
         end
         CLASS_BREAK: begin
            fric = break_f_ff;
            grav = break_g_ff;
         end
         default: begin
            fric = fog_f_ff;
            grav = fog_g_ff;
         end
      endcase
   end

   always_comb begin
      vx_new = friction(rd_rec.vx, fric);
      vy_new = friction(rd_rec.vy, fric);
      vy_sum = $signed({vy_new[VEL_W-1], vy_new}) + $signed((VEL_W+1)'(grav));
      if (vy_sum > VMAX) begin
         vy_sum = VMAX;
      end else if (vy_sum < VMIN) begin
         vy_sum = VMIN;
      end
      x_new     = integrate(rd_rec.x, vx_ff);
      y_new     = integrate(rd_rec.y, vy_ff);
      diff_life = (total_ff >= left_ff) ? total_ff - left_ff : '0;
      frames_m1 = frames_ff - 4'd1;
      frame_q   = (div_rsp.quot > {4'd0, frames_m1}) ? frames_m1 : div_rsp.quot[3:0];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_data.cmd == CMD_TICK) ? ST_TK_SCAN : ST_SP_SCAN;
            end
         end
         ST_SP_SCAN: begin
            if (at_end || !cur_live) begin
               state_in = ST_SP_RSP;
            end
         end
         ST_SP_RSP: begin
            if (!rsp_valid_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_TK_SCAN: begin
            if (at_end) begin
               state_in = ST_TK_FIN;
            end else if (cur_live) begin
               state_in = ST_TK_UPD;
            end
         end
         ST_TK_UPD: begin
            state_in = (rd_rec.left <= LIFE_W'(1)) ? ST_TK_SCAN : ST_TK_POS;
         end
         ST_TK_POS: begin
            state_in = (frames_ff > 4'd1) ? ST_TK_DIV1 : ST_TK_EMIT;
         end
         ST_TK_DIV1: begin
            if (div_rsp.done) begin
               state_in = (div_rsp.quot == '0) ? ST_TK_EMIT : ST_TK_DIV2;
            end
         end
         ST_TK_DIV2: begin
            if (div_rsp.done) begin
               state_in = ST_TK_EMIT;
            end
         end
         ST_TK_EMIT: begin
            if (!rsp_valid_ff) begin
               state_in = ST_TK_SCAN;
            end
         end
         ST_TK_FIN: begin
            if (!rsp_valid_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ram and divider controls
   always_comb begin
      ram_we           = 1'b0;
      wr_rec           = rd_rec;
      div_req.start    = 1'b0;
      div_req.dividend = total_ff;
      div_req.divisor  = {4'd0, frames_ff};
      unique case (state_ff)
         ST_SP_SCAN: begin
            ram_we        = !at_end && !cur_live;
            wr_rec.x      = req_ff.start_x;
            wr_rec.y      = req_ff.start_y;
            wr_rec.vx     = req_ff.start_vx;
            wr_rec.vy     = req_ff.start_vy;
            wr_rec.left   = req_ff.life_ticks;
            wr_rec.total  = req_ff.life_ticks;
            wr_rec.pclass = req_ff.particle_class;
            wr_rec.frames = req_ff.frame_count;
         end
         ST_TK_POS: begin
            ram_we        = 1'b1;
            wr_rec.x      = x_new;
            wr_rec.y      = y_new;
            wr_rec.vx     = vx_ff;
            wr_rec.vy     = vy_ff;
            wr_rec.left   = left_ff;
            div_req.start = (frames_ff > 4'd1);
         end
         ST_TK_DIV1: begin
            div_req.start    = div_rsp.done && (div_rsp.quot != '0);
            div_req.dividend = diff_life;
            div_req.divisor  = div_rsp.quot;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         star_f_ff     <= RST_STAR_F;
         star_g_ff     <= RST_STAR_G;
         break_f_ff    <= RST_BREAK_F;
         break_g_ff    <= RST_BREAK_G;
         fog_f_ff      <= RST_FOG_F;
         fog_g_ff      <= RST_FOG_G;
         live_ff       <= '0;
         idx_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_STAR_FRICTION:  star_f_ff  <= csr_data;
               CSR_STAR_GRAVITY:   star_g_ff  <= csr_data;
               CSR_BREAK_FRICTION: break_f_ff <= csr_data;
               CSR_BREAK_GRAVITY:  break_g_ff <= csr_data;
               CSR_FOG_FRICTION:   fog_f_ff   <= csr_data;
               CSR_FOG_GRAVITY:    fog_g_ff   <= csr_data;
               default: begin
               end
            endcase
         end
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               idx_ff <= '0;
            end
            ST_SP_SCAN: begin
               if (!at_end && !cur_live) begin
                  live_ff[addr] <= 1'b1;
               end else if (!at_end) begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            ST_SP_RSP: begin
               if (!rsp_valid_ff) begin
                  rsp_valid_ff <= 1'b1;
               end
            end
            ST_TK_SCAN: begin
               if (!at_end && !cur_live) begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            ST_TK_UPD: begin
               if (rd_rec.left <= LIFE_W'(1)) begin
                  live_ff[addr] <= 1'b0;
                  idx_ff        <= idx_ff + 1'b1;
               end
            end
            ST_TK_EMIT: begin
               if (!rsp_valid_ff) begin
                  if (pend_valid_ff) begin
                     rsp_valid_ff <= 1'b1;
                  end
                  pend_valid_ff <= 1'b1;
                  idx_ff        <= idx_ff + 1'b1;
               end
            end
            ST_TK_FIN: begin
               if (!rsp_valid_ff) begin
                  rsp_valid_ff  <= 1'b1;
                  pend_valid_ff <= 1'b0;
               end
            end
            default: begin
            end
         endcase
      end

      // payload registers
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
      unique case (state_ff)
         ST_SP_SCAN: begin
            full_ff <= at_end;
         end
         ST_SP_RSP: begin
            if (!rsp_valid_ff) begin
               rsp_ff.last <= 1'b1;
               if (full_ff) begin
                  rsp_ff.status <= STATUS_FULL;
                  rsp_ff.slot   <= '0;
                  rsp_ff.pos_x  <= '0;
                  rsp_ff.pos_y  <= '0;
                  rsp_ff.frame  <= '0;
               end else begin
                  rsp_ff.status <= STATUS_SPAWN;
                  rsp_ff.slot   <= 6'(idx_ff);
                  rsp_ff.pos_x  <= req_ff.start_x;
                  rsp_ff.pos_y  <= req_ff.start_y;
                  rsp_ff.frame  <= '0;
               end
            end
         end
         ST_TK_UPD: begin
            vx_ff     <= vx_new;
            vy_ff     <= vy_sum[VEL_W-1:0];
            left_ff   <= rd_rec.left - 1'b1;
            total_ff  <= rd_rec.total;
            frames_ff <= rd_rec.frames;
         end
         ST_TK_POS: begin
            x_ff     <= x_new;
            y_ff     <= y_new;
            frame_ff <= '0;
         end
         ST_TK_DIV1: begin
            // zero divisor gives the last frame
            if (div_rsp.done && div_rsp.quot == '0) begin
               frame_ff <= frames_m1;
            end
         end
         ST_TK_DIV2: begin
            if (div_rsp.done) begin
               frame_ff <= frame_q;
            end
         end
         ST_TK_EMIT: begin
            // one report held back so the final one can carry last
            if (!rsp_valid_ff) begin
               rsp_ff         <= pend_ff;
               pend_ff.status <= STATUS_REPORT;
               pend_ff.slot   <= 6'(idx_ff);
               pend_ff.pos_x  <= x_ff;
               pend_ff.pos_y  <= y_ff;
               pend_ff.frame  <= frame_ff;
               pend_ff.last   <= 1'b0;
            end
         end
         ST_TK_FIN: begin
            if (!rsp_valid_ff) begin
               if (pend_valid_ff) begin
                  rsp_ff      <= pend_ff;
                  rsp_ff.last <= 1'b1;
               end else begin
                  rsp_ff.status <= STATUS_NONE;
                  rsp_ff.slot   <= '0;
                  rsp_ff.pos_x  <= '0;
                  rsp_ff.pos_y  <= '0;
                  rsp_ff.frame  <= '0;
                  rsp_ff.last   <= 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

endmodule

// ----- sv/ppu_ram.sv -----
// ----------------------------------------------------------------------------
// ppu_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ppu_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- sv/ppu_div.sv -----
// ----------------------------------------------------------------------------
// ppu_div
// Restoring divider for 8-bit unsigned operands, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module ppu_div
   import ppu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   localparam int CNT_W = $clog2(LIFE_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [LIFE_W-1:0] rem_ff, rem_in;
   logic [LIFE_W-1:0] quot_ff, quot_in;
   logic [LIFE_W-1:0] dvs_ff, dvs_in;
   logic [LIFE_W:0]   shifted;
   logic [LIFE_W:0]   diff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      dvs_in  = dvs_ff;
      shifted = {rem_ff, quot_ff[LIFE_W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quot_in = div_req.dividend;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         if (!diff[LIFE_W]) begin
            rem_in  = diff[LIFE_W-1:0];
            quot_in = {quot_ff[LIFE_W-2:0], 1'b1};
         end else begin
            rem_in  = shifted[LIFE_W-1:0];
            quot_in = {quot_ff[LIFE_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(LIFE_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      dvs_ff  <= dvs_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;

endmodule
